[sv/connection_rotation_lifecycle_fsm_top_assert.svh]
// Assertion macros shared by the lifecycle block.
`ifndef CONNECTION_ROTATION_LIFECYCLE_FSM_TOP_ASSERT_SVH
`define CONNECTION_ROTATION_LIFECYCLE_FSM_TOP_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define CRL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define CRL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/crl_pkg.sv]
`default_nettype none

package crl_pkg;

  localparam int CRL_TIME_WIDTH = 64;
  localparam int CRL_ATT_WIDTH  = 32;
  localparam int CRL_CFG_AW     = 5;
  localparam int CRL_CFG_DW     = 64;
  localparam int CRL_IN_DW      = 240;
  localparam int CRL_IN_UW      = 3;
  localparam int CRL_OUT_DW     = 48;

  typedef enum logic [2:0] {
    PH_WARMUP   = 3'd0,
    PH_ELIGIBLE = 3'd1,
    PH_PENDING  = 3'd2,
    PH_DRAINING = 3'd3,
    PH_RETIRED  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EX_NONE     = 3'd0,
    EX_WARMUP   = 3'd1,
    EX_AUTH     = 3'd2,
    EX_SHUTDOWN = 3'd3,
    EX_BUDGET   = 3'd4,
    EX_CHURN    = 3'd5,
    EX_UNSAFE   = 3'd6
  } ex_t;

  typedef enum logic [2:0] {
    CMD_POLL     = 3'd0,
    CMD_REARM    = 3'd1,
    CMD_ELIGIBLE = 3'd2,
    CMD_SREADY   = 3'd3,
    CMD_SFAIL    = 3'd4
  } cmd_t;

  // register word index (paddr[4:3])
  typedef enum logic [1:0] {
    REG_ENABLE  = 2'd0,
    REG_CEILING = 2'd1,
    REG_OVERLAP = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic        rotation_enable;
    logic [63:0] age_limit_ms;
    logic [31:0] drain_limit_ms;
  } crl_cfg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] now_ms;
    logic [63:0] opened_at;
    logic [63:0] rotate_after;
    logic [31:0] backoff_ms;
    logic [2:0]  failure_reason;
    logic        inflight;
    logic        auth_busy;
    logic        shutdown_req;
    logic        budget_ok;
    logic        churn_ok;
    logic        unsafe_point;
  } crl_item_t;

  typedef struct packed {
    logic        open_successor;
    logic        route_to_successor;
    logic        retire_conn;
    logic        over_age;
    logic        accepted;
    phase_t      phase;
    ex_t         exemption;
    logic [31:0] attempts;
  } crl_res_t;

endpackage

`default_nettype wire

[sv/crl_cfg.sv]
`default_nettype none

module crl_cfg
  import crl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CRL_CFG_AW-1:0] paddr,
  input  wire logic [CRL_CFG_DW-1:0] pwdata,
  output logic      [CRL_CFG_DW-1:0] prdata,
  output crl_cfg_t                   cfg_o
);

  crl_cfg_t regs_r, regs_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[CRL_CFG_AW-1:CRL_CFG_AW-2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (idx)
        REG_ENABLE:  regs_nxt.rotation_enable = pwdata[0];
        REG_CEILING: regs_nxt.age_limit_ms    = pwdata;
        REG_OVERLAP: regs_nxt.drain_limit_ms  = pwdata[31:0];
        default:     regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE:  prdata = {63'd0, regs_r.rotation_enable};
      REG_CEILING: prdata = regs_r.age_limit_ms;
      REG_OVERLAP: prdata = {32'd0, regs_r.drain_limit_ms};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = regs_r;

endmodule

`default_nettype wire

[sv/crl_core.sv]
`default_nettype none

`include "connection_rotation_lifecycle_fsm_top_assert.svh"

module crl_core
  import crl_pkg::*;
#(
  parameter int TIME_WIDTH = CRL_TIME_WIDTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step_i,
  input  wire crl_item_t item_i,
  input  wire crl_cfg_t  cfg_i,
  output crl_res_t       res_o
);

  localparam int TW = TIME_WIDTH;
  localparam logic [CRL_ATT_WIDTH-1:0] ATT_MAX = '1;

  phase_t                   phase_r, phase_nxt;
  ex_t                      ex_r, ex_nxt;
  logic [TW-1:0]            open_r, open_nxt;
  logic [TW-1:0]            rotate_r, rotate_nxt;
  logic [TW-1:0]            drain_r, drain_nxt;
  logic [TW-1:0]            retry_r, retry_nxt;
  logic [CRL_ATT_WIDTH-1:0] attempt_r, attempt_nxt;
  logic                     succ_r, succ_nxt;
  logic                     cut_r, cut_nxt;

  cmd_t          cmd;
  logic [TW-1:0] now_t;
  logic          poll_live;
  logic          elig_due;
  logic          pend;
  ex_t           supp;
  ex_t           fail_ex;
  logic [TW:0]   retry_sum;
  logic [TW-1:0] retry_sat;
  logic [TW:0]   ovl_sum;
  logic [TW-1:0] ovl_lim;
  logic          ovl_expired;
  logic [64:0]   ceil_sum;
  logic          ceil_hit;
  logic          retire;

  assign cmd   = cmd_t'(item_i.command);
  assign now_t = item_i.now_ms[TW-1:0];

  assign poll_live = cfg_i.rotation_enable && (phase_r != PH_RETIRED);
  assign elig_due  = (phase_r == PH_ELIGIBLE) && (rotate_r != '0) && (now_t >= rotate_r);
  assign pend      = (phase_r == PH_PENDING) || elig_due;

  // suppression reasons, highest priority first
  always_comb begin
    if (item_i.auth_busy)          supp = EX_AUTH;
    else if (item_i.shutdown_req)  supp = EX_SHUTDOWN;
    else if (!item_i.budget_ok)    supp = EX_BUDGET;
    else if (!item_i.churn_ok)     supp = EX_CHURN;
    else if (item_i.unsafe_point)  supp = EX_UNSAFE;
    else                           supp = EX_NONE;
  end

  assign fail_ex = (item_i.failure_reason > EX_UNSAFE) ? EX_UNSAFE
                                                       : ex_t'(item_i.failure_reason);

  assign retry_sum = {1'b0, now_t} + {{(TW + 1 - 32){1'b0}}, item_i.backoff_ms};
  assign retry_sat = retry_sum[TW] ? '1 : retry_sum[TW-1:0];

  assign ovl_sum     = {1'b0, drain_r} + {{(TW + 1 - 32){1'b0}}, cfg_i.drain_limit_ms};
  assign ovl_lim     = ovl_sum[TW] ? '1 : ovl_sum[TW-1:0];
  assign ovl_expired = (cfg_i.drain_limit_ms != '0) && (now_t >= ovl_lim);

  // a ceiling that runs past the time range counts as reached
  assign ceil_sum = {1'b0, cfg_i.age_limit_ms} + {{(65 - TW){1'b0}}, open_r};
  assign ceil_hit = (cfg_i.age_limit_ms != '0)
                    && ((|ceil_sum[64:TW]) || (now_t >= ceil_sum[TW-1:0]));

  assign retire = (phase_r == PH_DRAINING) && (!item_i.inflight || ovl_expired);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step_i) begin
      case (cmd)
        CMD_POLL: begin
          if (poll_live) begin
            if (elig_due)    phase_nxt = PH_PENDING;
            else if (retire) phase_nxt = PH_RETIRED;
          end
        end
        CMD_REARM:    phase_nxt = PH_WARMUP;
        CMD_ELIGIBLE: if (phase_r == PH_WARMUP) phase_nxt = PH_ELIGIBLE;
        CMD_SREADY:   if (succ_r && phase_r == PH_PENDING) phase_nxt = PH_DRAINING;
        default:      phase_nxt = phase_r;
      endcase
    end
  end

  // datapath state and decision flags
  always_comb begin
    ex_nxt      = ex_r;
    open_nxt    = open_r;
    rotate_nxt  = rotate_r;
    drain_nxt   = drain_r;
    retry_nxt   = retry_r;
    attempt_nxt = attempt_r;
    succ_nxt    = succ_r;
    cut_nxt     = cut_r;
    res_o       = '0;
    if (step_i) begin
      case (cmd)
        CMD_POLL: begin
          if (poll_live) begin
            if (phase_r == PH_WARMUP) begin
              ex_nxt = EX_WARMUP;
            end else if (pend) begin
              if (cut_r) begin
                res_o.route_to_successor = 1'b1;
                cut_nxt = 1'b0;
              end else if (supp != EX_NONE) begin
                ex_nxt = supp;
                res_o.over_age = ceil_hit;
              end else if (!succ_r && now_t >= retry_r) begin
                succ_nxt = 1'b1;
                if (attempt_r != ATT_MAX) attempt_nxt = attempt_r + 1'b1;
                ex_nxt = EX_NONE;
                res_o.open_successor = 1'b1;
              end
            end else if (phase_r == PH_DRAINING) begin
              if (cut_r) begin
                res_o.route_to_successor = 1'b1;
                cut_nxt = 1'b0;
              end
              if (retire) begin
                succ_nxt = 1'b0;
                res_o.retire_conn = 1'b1;
              end
            end
          end
        end
        CMD_REARM: begin
          ex_nxt      = EX_WARMUP;
          open_nxt    = item_i.opened_at[TW-1:0];
          rotate_nxt  = item_i.rotate_after[TW-1:0];
          drain_nxt   = '0;
          retry_nxt   = '0;
          attempt_nxt = '0;
          succ_nxt    = 1'b0;
          cut_nxt     = 1'b0;
        end
        CMD_ELIGIBLE: begin
          if (phase_r == PH_WARMUP) ex_nxt = EX_NONE;
        end
        CMD_SREADY: begin
          if (succ_r && phase_r == PH_PENDING) begin
            drain_nxt      = now_t;
            cut_nxt        = 1'b1;
            ex_nxt         = EX_NONE;
            res_o.accepted = 1'b1;
          end
        end
        CMD_SFAIL: begin
          if (phase_r == PH_PENDING) begin
            succ_nxt  = 1'b0;
            cut_nxt   = 1'b0;
            ex_nxt    = fail_ex;
            retry_nxt = retry_sat;
          end
        end
        default: ex_nxt = ex_r;
      endcase
    end
    res_o.phase     = phase_nxt;
    res_o.exemption = ex_nxt;
    res_o.attempts  = attempt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WARMUP;
      ex_r      <= EX_WARMUP;
      open_r    <= '0;
      rotate_r  <= '0;
      drain_r   <= '0;
      retry_r   <= '0;
      attempt_r <= '0;
      succ_r    <= 1'b0;
      cut_r     <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      ex_r      <= ex_nxt;
      open_r    <= open_nxt;
      rotate_r  <= rotate_nxt;
      drain_r   <= drain_nxt;
      retry_r   <= retry_nxt;
      attempt_r <= attempt_nxt;
      succ_r    <= succ_nxt;
      cut_r     <= cut_nxt;
    end
  end

  `CRL_ASSERT_NXT(a_att_mono, clk, rst_n, !(step_i && cmd == CMD_REARM), attempt_r >= $past(attempt_r), "attempt count went down without rearm")
  `CRL_ASSERT_NXT(a_retired_holds, clk, rst_n, phase_r == PH_RETIRED && !(step_i && cmd == CMD_REARM), phase_r == PH_RETIRED, "left retired without rearm")
  `CRL_ASSERT_NOW(a_cut_drain, clk, rst_n, cut_r, phase_r == PH_DRAINING, "cutover pending outside draining")
  `CRL_ASSERT_NOW(a_accept_drain, clk, rst_n, res_o.accepted, phase_nxt == PH_DRAINING && succ_r, "successor accepted without draining")

endmodule

`default_nettype wire

[sv/connection_rotation_lifecycle_fsm_top.sv]
// An accepted beat is held in the input stage, then registered into the result register that drives out_tvalid.
// Throughput: one beat per cycle; a stall holds both stages and in_tready drops once full.
// All decision logic sits between the input stage and the result register.
// Reset (rst_n low, synchronous): phase warmup, exemption warmup, times, attempts,
// flags and configuration registers cleared; both stages empty.
`default_nettype none

module connection_rotation_lifecycle_fsm_top
  import crl_pkg::*;
#(
  parameter int TIME_WIDTH = CRL_TIME_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // now_ms[63:0], opened_at[127:64], rotate_after[191:128], backoff_ms[223:192],
  // failure_reason[226:224], inflight[227], auth_busy[228], shutdown_req[229],
  // budget_ok[230], churn_ok[231], unsafe_point[232], zero pad above
  input  wire logic [CRL_IN_DW-1:0]  in_tdata,
  // command[2:0]
  input  wire logic [CRL_IN_UW-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // open_successor[0], route_to_successor[1], retire_conn[2], over_age[3],
  // accepted[4], phase[7:5], exemption[10:8], attempts[42:11], zero pad above
  output logic      [CRL_OUT_DW-1:0] out_tdata,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CRL_CFG_AW-1:0] cfg_paddr,
  input  wire logic [CRL_CFG_DW-1:0] cfg_pwdata,
  output logic      [CRL_CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  crl_cfg_t  cfg;
  crl_item_t in_item, item_r;
  crl_res_t  res, res_r;
  logic      in_valid_r, in_valid_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      adv, step, in_fire;

  assign cfg_pready = 1'b1;

  crl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg_o   (cfg)
  );

  always_comb begin
    in_item.command        = in_tuser;
    in_item.now_ms         = in_tdata[63:0];
    in_item.opened_at      = in_tdata[127:64];
    in_item.rotate_after   = in_tdata[191:128];
    in_item.backoff_ms     = in_tdata[223:192];
    in_item.failure_reason = in_tdata[226:224];
    in_item.inflight       = in_tdata[227];
    in_item.auth_busy      = in_tdata[228];
    in_item.shutdown_req   = in_tdata[229];
    in_item.budget_ok      = in_tdata[230];
    in_item.churn_ok       = in_tdata[231];
    in_item.unsafe_point   = in_tdata[232];
  end

  // input stage drains into the result register whenever that can take a beat
  assign adv       = !out_valid_r || out_tready;
  assign step      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  assign in_valid_nxt  = in_fire ? 1'b1 : (step ? 1'b0 : in_valid_r);
  assign out_valid_nxt = step ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  crl_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .item_i (item_r),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_item;
    if (step)    res_r  <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.attempts, res_r.exemption, res_r.phase, res_r.accepted,
                       res_r.over_age, res_r.retire_conn, res_r.route_to_successor,
                       res_r.open_successor};

endmodule

`default_nettype wire
